// File: rtl/serial_command_line_wear_store_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial command line wear store.
// Every macro samples on the rising edge of clk and is switched off while rst
// is high.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_LINE_WEAR_STORE_TOP_ASSERT_SVH
`define SERIAL_COMMAND_LINE_WEAR_STORE_TOP_ASSERT_SVH

// The condition must never be true.
`define SCWL_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define SCWL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define SCWL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/scwl_pkg.sv
// ----------------------------------------------------------------------------
// scwl_pkg
// Shared constants and types of the serial command line wear store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scwl_pkg;

  // Line buffer length and number of wear-levelled slots.
  localparam int LINE_LENGTH = 30;
  localparam int SLOT_COUNT  = 20;

  // Derived widths.
  localparam int POS_W   = $clog2(LINE_LENGTH + 1);
  localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LAST_SLOT = SLOT_COUNT - 1;
  localparam int ACTIVE_W = 5;
  localparam int COUNT_W  = 17;
  localparam int VALUE_W  = 8;

  // Queue depths between the stages.
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Byte codes.
  localparam logic [7:0] CTRL_TOP    = 8'h1F;
  localparam logic [7:0] CR_BYTE     = 8'h0D;
  localparam logic [7:0] CMD_OUT     = 8'h4F;
  localparam logic [7:0] CMD_RESTART = 8'h52;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] WEAR_RESET = 17'd100000;

  // One classified beat passed from the line parser to the store.
  typedef struct packed {
    logic               is_out;
    logic               is_restart;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  // One finished result beat.
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic                alive;
    logic                restart;
    logic                written;
    logic [ACTIVE_W-1:0] slot;
    logic                full;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/scwl_front.sv
// ----------------------------------------------------------------------------
// scwl_front
// Line assembler and atoi-style parser; turns each byte into one command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scwl_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   rx_byte,
  input  wire logic         overrun,
  output scwl_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_NUM  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  logic [scwl_pkg::POS_W-1:0] line_pos, line_pos_next, pos_eff;
  logic [7:0]                 first_char, first_char_next;
  phase_t                     phase, phase_next;
  logic                       negative, negative_next;
  logic [7:0]                 accum, accum_next;
  logic                       digit;
  logic [7:0]                 dval;

  assign digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign dval  = rx_byte - 8'h30;
  assign pos_eff = (line_pos >= scwl_pkg::POS_W'(scwl_pkg::LINE_LENGTH)) ? '0 : line_pos;

  always_comb begin
    line_pos_next   = line_pos;
    first_char_next = first_char;
    phase_next      = phase;
    negative_next   = negative;
    accum_next      = accum;
    cmd             = '0;
    if (accept && !overrun) begin
      line_pos_next = pos_eff;
      if (rx_byte > scwl_pkg::CTRL_TOP) begin
        if (pos_eff == '0) begin
          // A byte at place zero starts a new line and a new parse.
          first_char_next = rx_byte;
          phase_next      = PH_SKIP;
          negative_next   = 1'b0;
          accum_next      = '0;
        end else begin
          case (phase)
            PH_SKIP: begin
              if (rx_byte == 8'h20) begin
                phase_next = PH_SKIP;
              end else if (rx_byte == 8'h2B) begin
                phase_next = PH_NUM;
              end else if (rx_byte == 8'h2D) begin
                negative_next = 1'b1;
                phase_next    = PH_NUM;
              end else if (digit) begin
                accum_next = dval;
                phase_next = PH_NUM;
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_NUM: begin
              if (digit) begin
                accum_next = (accum << 3) + (accum << 1) + dval;
              end else begin
                phase_next = PH_DONE;
              end
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
        line_pos_next = pos_eff + 1'b1;
      end else if (rx_byte == scwl_pkg::CR_BYTE && pos_eff != '0) begin
        line_pos_next  = '0;
        cmd.is_out     = (first_char == scwl_pkg::CMD_OUT);
        cmd.is_restart = (first_char == scwl_pkg::CMD_RESTART);
        cmd.value      = negative ? (8'd0 - accum) : accum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos   <= '0;
      first_char <= '0;
      phase      <= PH_SKIP;
      negative   <= 1'b0;
      accum      <= '0;
    end else begin
      line_pos   <= line_pos_next;
      first_char <= first_char_next;
      phase      <= phase_next;
      negative   <= negative_next;
      accum      <= accum_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/scwl_cmd_queue.sv
// ----------------------------------------------------------------------------
// scwl_cmd_queue
// Short queue of classified commands between the parser and the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scwl_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  scwl_pkg::cmd_t     cmd_in,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output scwl_pkg::cmd_t     cmd_out
);

  localparam int PTR_W = (scwl_pkg::CMD_DEPTH > 1) ? $clog2(scwl_pkg::CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(scwl_pkg::CMD_DEPTH + 1);

  scwl_pkg::cmd_t     slots [scwl_pkg::CMD_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign full    = (count == CNT_W'(scwl_pkg::CMD_DEPTH));
  assign valid   = (count != '0);
  assign cmd_out = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(scwl_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(scwl_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/scwl_back.sv
// ----------------------------------------------------------------------------
// scwl_back
// Output register, wear-levelled store and result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scwl_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [scwl_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  wire logic                          cmd_valid,
  input  scwl_pkg::cmd_t                     cmd,
  output logic                               cmd_pop,
  output logic                               res_valid,
  input  wire logic                          res_pop,
  output scwl_pkg::result_t                  res
);

  `include "serial_command_line_wear_store_top_assert.svh"

  localparam int PTR_W = (scwl_pkg::RES_DEPTH > 1) ? $clog2(scwl_pkg::RES_DEPTH) : 1;
  localparam int CNT_W = $clog2(scwl_pkg::RES_DEPTH + 1);

  // Slots are only ever entered in increasing order and never revisited, so
  // only the active slot's value and counter are kept. A newly entered slot
  // holds the value just written and a counter of zero.
  logic [scwl_pkg::COUNT_W-1:0] wear_limit;
  logic [scwl_pkg::VALUE_W-1:0] output_reg, output_reg_next;
  logic [scwl_pkg::SLOT_W-1:0]  slot_index, slot_index_next;
  logic [scwl_pkg::VALUE_W-1:0] cur_value, cur_value_next;
  logic [scwl_pkg::COUNT_W-1:0] cur_count, cur_count_next, count_inc;
  logic                         differ, adv;

  scwl_pkg::result_t            res_in;
  scwl_pkg::result_t            rq [scwl_pkg::RES_DEPTH];
  logic [PTR_W-1:0]             wr_ptr, rd_ptr;
  logic [CNT_W-1:0]             rq_count;
  logic                         rq_full, res_push, do_pop;

  assign rq_full  = (rq_count == CNT_W'(scwl_pkg::RES_DEPTH));
  assign res_push = cmd_valid && !rq_full;
  assign cmd_pop  = res_push;
  assign res_valid = (rq_count != '0);
  assign do_pop   = res_pop && res_valid;
  assign res      = rq[rd_ptr];

  assign differ    = (cmd.value != cur_value);
  assign count_inc = (cur_count != scwl_pkg::COUNT_MAX) ? cur_count + 1'b1 : cur_count;
  assign adv       = cmd.is_out && differ && (count_inc >= wear_limit) &&
                     (slot_index != scwl_pkg::SLOT_W'(scwl_pkg::LAST_SLOT));

  always_comb begin
    output_reg_next = output_reg;
    slot_index_next = slot_index;
    cur_value_next  = cur_value;
    cur_count_next  = cur_count;
    if (cmd.is_out) begin
      output_reg_next = cmd.value;
      if (differ) begin
        cur_value_next = cmd.value;
        if (adv) begin
          slot_index_next = slot_index + 1'b1;
          cur_count_next  = '0;
        end else begin
          cur_count_next = count_inc;
        end
      end
    end
    res_in.value   = output_reg_next;
    res_in.alive   = cmd.is_out;
    res_in.restart = cmd.is_restart;
    res_in.written = cmd.is_out && differ;
    res_in.slot    = scwl_pkg::ACTIVE_W'(slot_index_next);
    res_in.full    = (slot_index_next == scwl_pkg::SLOT_W'(scwl_pkg::LAST_SLOT)) &&
                     (cur_count_next >= wear_limit);
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wear_limit <= scwl_pkg::WEAR_RESET;
      output_reg <= '0;
      slot_index <= '0;
      cur_value  <= '0;
      cur_count  <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      rq_count   <= '0;
    end else begin
      if (cfg_wr_en) begin
        wear_limit <= cfg_wr_data;
      end
      if (res_push) begin
        output_reg <= output_reg_next;
        slot_index <= slot_index_next;
        cur_value  <= cur_value_next;
        cur_count  <= cur_count_next;
        wr_ptr     <= (wr_ptr == PTR_W'(scwl_pkg::RES_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(scwl_pkg::RES_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (res_push && !do_pop) begin
        rq_count <= rq_count + 1'b1;
      end else if (do_pop && !res_push) begin
        rq_count <= rq_count - 1'b1;
      end
    end
  end

  // The active slot never runs past the last slot and never moves backward.
  `SCWL_ASSERT_NEVER(a_slot_range, slot_index > scwl_pkg::SLOT_W'(scwl_pkg::LAST_SLOT), "slot index past last slot")
  `SCWL_ASSERT_NEXT(a_slot_monotonic, 1'b1, slot_index >= $past(slot_index), "slot index moved backward")
  // Entering a new slot leaves it holding the new value with a fresh counter.
  `SCWL_ASSERT_NEXT(a_advance_fresh, res_push && adv, (cur_count == '0) && (cur_value == $past(cmd.value)), "new slot not fresh")
  // A store write only happens on an output command.
  `SCWL_ASSERT_IMPLY(a_written_alive, res_push && res_in.written, res_in.alive && !res_in.restart, "store write without output command")

endmodule

`default_nettype wire

// File: rtl/serial_command_line_wear_store_top.sv
// ----------------------------------------------------------------------------
// serial_command_line_wear_store_top
// Serial command line parser driving an output register and a wear store.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Beat contents
//   -------   ----------------   -----------------------------------------
//   input     push / full        rx_byte, overrun
//   result    empty / pop        output_value, pin_drive, alive_pulse,
//                                restart_request, store_written,
//                                active_slot, store_full
//   config    cfg_wr_en          cfg_wr_data (wear_limit, 17 bits)
//
// One input beat can be taken every cycle while full is low, and every
// input beat yields one result beat. A taken beat's command is registered
// in the command queue, and the store stage then writes its result into the
// result queue, from which it is shown on the result ports; a full result
// queue holds the command back. Reset is synchronous; the store keeps only
// the active slot's value and counter, so there is no clearing sweep. A
// stalled result side fills the result queue, then the command queue, and
// only then raises full.
//
// The front stage collects printable bytes into a line and parses the
// decimal argument as the bytes arrive, so a carriage return can turn the
// finished line straight into a command. The back stage applies output
// commands to the output register and to the wear-levelled store, where a
// slot's write counter reaching wear_limit moves writes to the next slot,
// stopping at the last one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_command_line_wear_store_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input channel.
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    rx_byte,
  input  wire logic                          overrun,
  // Result channel.
  output logic                               empty,
  input  wire logic                          pop,
  output logic [7:0]                         output_value,
  output logic [3:0]                         pin_drive,
  output logic                               alive_pulse,
  output logic                               restart_request,
  output logic                               store_written,
  output logic [4:0]                         active_slot,
  output logic                               store_full,
  // Configuration port.
  input  wire logic                          cfg_wr_en,
  input  wire logic [scwl_pkg::COUNT_W-1:0]  cfg_wr_data
);

  scwl_pkg::cmd_t    front_cmd, queued_cmd;
  scwl_pkg::result_t res;
  logic              accept, cmd_valid, cmd_pop, res_valid;

  // An input beat is taken whenever the command queue has room.
  assign accept = push && !full;

  scwl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .overrun (overrun),
    .cmd     (front_cmd)
  );

  scwl_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .cmd_in  (front_cmd),
    .full    (full),
    .pop     (cmd_pop),
    .valid   (cmd_valid),
    .cmd_out (queued_cmd)
  );

  scwl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd         (queued_cmd),
    .cmd_pop     (cmd_pop),
    .res_valid   (res_valid),
    .res_pop     (pop),
    .res         (res)
  );

  // The oldest waiting result sits on the ports while empty is low.
  assign empty           = !res_valid;
  assign output_value    = res.value;
  assign pin_drive       = res.value[3:0];
  assign alive_pulse     = res.alive;
  assign restart_request = res.restart;
  assign store_written   = res.written;
  assign active_slot     = res.slot;
  assign store_full      = res.full;

endmodule

`default_nettype wire

// File: bench/serial_command_line_wear_store_top_test.sv
// ----------------------------------------------------------------------------
// serial_command_line_wear_store_top_test
// Self-checking bench for the serial command line wear store. Byte beats are
// driven through the push/full queue, every result beat is checked against a
// cycle-free model of the line parser, the output register and the
// wear-levelled slot store, over several wear limits and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_command_line_wear_store_top_test;

  // Characters the number parser cares about.
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [7:0] LOWEST_PRINTABLE = 8'h20;

  // Least number of live beats queued per phase once the directed lines are out.
  localparam int PHASE_BYTES = 200;
  // Length of the long receiver hold-off, in clock cycles.
  localparam int HOLDOFF_CYCLES = 400;

  typedef enum logic [1:0] {SKIP_BLANKS, IN_NUMBER, NUMBER_DONE} parse_state_t;

  // One serial byte as it leaves the receiver.
  typedef struct {
    logic [7:0] data;
    logic       dropped;
  } serial_beat_t;

  // One result beat, in the order of the result ports.
  typedef struct packed {
    logic [7:0] value;
    logic [3:0] pins;
    logic       alive;
    logic       restart;
    logic       written;
    logic [4:0] slot;
    logic       full;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] rx_byte = 8'h00;
  logic overrun = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] output_value;
  logic [3:0] pin_drive;
  logic alive_pulse;
  logic restart_request;
  logic store_written;
  logic [4:0] active_slot;
  logic store_full;
  logic cfg_wr_en = 1'b0;
  logic [scwl_pkg::COUNT_W-1:0] cfg_wr_data = '0;

  serial_command_line_wear_store_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .rx_byte         (rx_byte),
    .overrun         (overrun),
    .empty           (empty),
    .pop             (pop),
    .output_value    (output_value),
    .pin_drive       (pin_drive),
    .alive_pulse     (alive_pulse),
    .restart_request (restart_request),
    .store_written   (store_written),
    .active_slot     (active_slot),
    .store_full      (store_full),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // --------------------------------------------------------------------------
  // Line and store model. It is advanced once for every byte beat that the
  // block takes, so it always describes the state right after that beat.
  // --------------------------------------------------------------------------
  logic [scwl_pkg::COUNT_W-1:0] wear_limit_now;
  int                           line_pos;
  logic [7:0]                   lead_char;
  parse_state_t                 parse_st;
  logic                         neg_sign;
  logic [7:0]                   accum;
  logic [7:0]                   out_reg;
  int                           slot;
  logic [7:0]                   slot_val [scwl_pkg::SLOT_COUNT];
  logic [scwl_pkg::COUNT_W-1:0] slot_cnt [scwl_pkg::SLOT_COUNT];

  initial begin
    wear_limit_now = scwl_pkg::WEAR_RESET;
    line_pos = 0;
    lead_char = '0;
    parse_st = SKIP_BLANKS;
    neg_sign = 1'b0;
    accum = '0;
    out_reg = '0;
    slot = 0;
    for (int i = 0; i < scwl_pkg::SLOT_COUNT; i++) begin
      slot_val[i] = '0;
      slot_cnt[i] = '0;
    end
  end

  // Feeds one character at place 1 or later to the atoi-style parser.
  function automatic void advance_parse(input logic [7:0] c);
    logic is_digit;
    is_digit = (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
    if (parse_st == SKIP_BLANKS) begin
      if (c == SPACE_CHAR) begin
        return;
      end
      if (c == PLUS_CHAR) begin
        parse_st = IN_NUMBER;
      end else if (c == MINUS_CHAR) begin
        neg_sign = 1'b1;
        parse_st = IN_NUMBER;
      end else if (is_digit) begin
        accum = c - DIGIT_ZERO;
        parse_st = IN_NUMBER;
      end else begin
        parse_st = NUMBER_DONE;
      end
    end else if (parse_st == IN_NUMBER) begin
      if (is_digit) begin
        accum = accum * 8'd10 + (c - DIGIT_ZERO);
      end else begin
        parse_st = NUMBER_DONE;
      end
    end
  endfunction

  // Writes a value into the active slot unless it is already held there.
  // A counter that reaches the wear limit moves the value into the next slot,
  // except at the last slot, which keeps taking writes.
  function automatic logic store_into_slot(input logic [7:0] v);
    int s;
    s = slot;
    if (slot_val[s] == v) begin
      return 1'b0;
    end
    if (slot_cnt[s] != scwl_pkg::COUNT_MAX) begin
      slot_cnt[s] = slot_cnt[s] + 1'b1;
    end
    if (slot_cnt[s] >= wear_limit_now && s + 1 < scwl_pkg::SLOT_COUNT) begin
      s = s + 1;
      slot = s;
    end
    slot_val[s] = v;
    return 1'b1;
  endfunction

  function automatic response_t predict_response(input logic [7:0] b, input logic dropped);
    response_t r;
    logic [7:0] v;
    r = '0;
    if (!dropped) begin
      if (line_pos >= scwl_pkg::LINE_LENGTH) begin
        line_pos = 0;
      end
      if (b > scwl_pkg::CTRL_TOP) begin
        if (line_pos == 0) begin
          lead_char = b;
          parse_st = SKIP_BLANKS;
          neg_sign = 1'b0;
          accum = '0;
        end else begin
          advance_parse(b);
        end
        line_pos++;
      end else if (b == scwl_pkg::CR_BYTE && line_pos != 0) begin
        line_pos = 0;
        if (lead_char == scwl_pkg::CMD_OUT) begin
          v = neg_sign ? 8'd0 - accum : accum;
          r.alive = 1'b1;
          out_reg = v;
          r.written = store_into_slot(v);
        end
        if (lead_char == scwl_pkg::CMD_RESTART) begin
          r.restart = 1'b1;
        end
      end
    end
    r.value = out_reg;
    r.pins = out_reg[3:0];
    r.slot = 5'(slot);
    r.full = (slot + 1 >= scwl_pkg::SLOT_COUNT) && (slot_cnt[slot] >= wear_limit_now);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Byte driver. It takes beats from bytes_to_send, holds a beat steady while
  // full is high, and idles at random according to send_idle_pct. Each beat
  // that the block takes is run through the model at that same edge.
  // --------------------------------------------------------------------------
  serial_beat_t bytes_to_send [$];
  response_t    awaited_responses [$];
  serial_beat_t outgoing;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  logic         receiver_hold = 1'b0;
  int           mismatch_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        awaited_responses.push_back(predict_response(rx_byte, overrun));
      end
      if (push && full) begin
        // The beat was not taken; keep it on the ports.
      end else if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        outgoing = bytes_to_send.pop_front();
        push <= 1'b1;
        rx_byte <= outgoing.data;
        overrun <= outgoing.dropped;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Every beat popped from the block is compared with the
  // oldest prediction. Pop stalls at random according to stall_pct, and is
  // held low for as long as receiver_hold is set.
  // --------------------------------------------------------------------------
  response_t observed;
  response_t wanted;

  task automatic flag_mismatch(input string why, input response_t want, input response_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected value=%0d pins=%0d alive=%0b restart=%0b written=%0b",
               $realtime, why, want.value, want.pins, want.alive, want.restart, want.written);
      $display("    slot=%0d full=%0b; got value=%0d pins=%0d alive=%0b restart=%0b",
               want.slot, want.full, got.value, got.pins, got.alive, got.restart);
      $display("    written=%0b slot=%0d full=%0b", got.written, got.slot, got.full);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        observed.value = output_value;
        observed.pins = pin_drive;
        observed.alive = alive_pulse;
        observed.restart = restart_request;
        observed.written = store_written;
        observed.slot = active_slot;
        observed.full = store_full;
        if (awaited_responses.size() == 0) begin
          flag_mismatch("result beat with nothing outstanding", '0, observed);
        end else begin
          wanted = awaited_responses.pop_front();
          if (observed !== wanted) begin
            flag_mismatch("result beat mismatch", wanted, observed);
          end
        end
      end
      pop <= !receiver_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Only beats without overrun count toward a phase, since
  // dropped bytes leave the block untouched.
  // --------------------------------------------------------------------------
  int live_bytes = 0;
  int last_number = 0;

  task automatic add_beat(input logic [7:0] data, input logic dropped);
    serial_beat_t sb;
    sb.data = data;
    sb.dropped = dropped;
    bytes_to_send.push_back(sb);
    if (!dropped) begin
      live_bytes++;
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_beat(s[i], 1'b0);
    end
  endtask

  task automatic add_printables(input int count);
    repeat (count) add_beat(8'($urandom_range(LOWEST_PRINTABLE, 8'hFF)), 1'b0);
  endtask

  // An output command: blanks, an optional sign, usually digits and sometimes junk
  // after them. About one in five reuses the previous number so that the
  // store sees values that it already holds.
  task automatic queue_out_line();
    int n;
    add_beat(scwl_pkg::CMD_OUT, 1'b0);
    repeat ($urandom_range(2)) add_beat(SPACE_CHAR, 1'b0);
    case ($urandom_range(3))
      0: add_beat(PLUS_CHAR, 1'b0);
      1: add_beat(MINUS_CHAR, 1'b0);
      default: ;
    endcase
    if ($urandom_range(4) == 0) begin
      n = last_number;
    end else begin
      case ($urandom_range(2))
        0: n = $urandom_range(9);
        1: n = $urandom_range(999);
        default: n = $urandom_range(99999);
      endcase
    end
    last_number = n;
    if ($urandom_range(9) != 0) begin
      add_text($sformatf("%0d", n));
    end
    if ($urandom_range(3) == 0) begin
      add_printables(1);
    end
    if ($urandom_range(15) == 0) begin
      add_beat(8'($urandom_range(255)), 1'b1);
    end
    add_beat(scwl_pkg::CR_BYTE, 1'b0);
  endtask

  task automatic queue_random(input int count);
    int start;
    start = live_bytes;
    while (live_bytes - start < count) begin
      case ($urandom_range(99)) inside
        [0:49]: queue_out_line();
        [50:59]: begin
          add_beat(scwl_pkg::CMD_RESTART, 1'b0);
          add_printables($urandom_range(3));
          add_beat(scwl_pkg::CR_BYTE, 1'b0);
        end
        [60:67]: begin
          // A full line of filler wraps to where it began, so the command lands at place 0 if the filler began there.
          add_printables(scwl_pkg::LINE_LENGTH);
          queue_out_line();
        end
        [68:74]: begin
          // Exactly full, where the carriage return is ignored, or longer.
          add_printables($urandom_range(1) ? scwl_pkg::LINE_LENGTH : $urandom_range(31, 62));
          add_beat(scwl_pkg::CR_BYTE, 1'b0);
        end
        default: begin
          repeat ($urandom_range(1, 8)) begin
            add_beat(8'($urandom_range(255)), $urandom_range(9) == 0);
          end
        end
      endcase
    end
  endtask

  // The block is idle once nothing is left to send and every prediction has
  // been matched; an extra wait then lets its two stages, the command and result queues, settle.
  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || push || awaited_responses.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_wear_limit(input logic [scwl_pkg::COUNT_W-1:0] limit);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    wear_limit_now = limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A limit of zero keeps the current register setting.
  task automatic run_phase(input int limit, input int idle, input int stall, input bit holdoff);
    wait_drained();
    if (limit != 0) begin
      write_wear_limit(scwl_pkg::COUNT_W'(limit));
    end
    send_idle_pct = idle;
    stall_pct = stall;
    queue_random(PHASE_BYTES);
    if (holdoff) begin
      // The receiver stops popping for a long stretch while the driver keeps
      // offering bytes, so both internal queues fill and full goes high.
      fork
        begin
          @(posedge clk);
          receiver_hold <= 1'b1;
          repeat (HOLDOFF_CYCLES) @(posedge clk);
          receiver_hold <= 1'b0;
        end
      join_none
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed lines under the reset wear limit: a bare command letter
    // (value 0, already held, so no write), a negative value, a blank and a
    // value past 255, the largest value, a restart, a carriage return on an
    // empty line, a dropped byte, low control bytes and the top byte value.
    add_text("O");
    add_beat(scwl_pkg::CR_BYTE, 1'b0);
    add_text("O-1");
    add_beat(scwl_pkg::CR_BYTE, 1'b0);
    add_text("O 300");
    add_beat(scwl_pkg::CR_BYTE, 1'b0);
    add_text("O255");
    add_beat(scwl_pkg::CR_BYTE, 1'b0);
    add_text("R");
    add_beat(scwl_pkg::CR_BYTE, 1'b0);
    add_beat(scwl_pkg::CR_BYTE, 1'b0);
    add_beat(scwl_pkg::CMD_OUT, 1'b1);
    add_beat(8'h00, 1'b0);
    add_beat(scwl_pkg::CTRL_TOP, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(scwl_pkg::CR_BYTE, 1'b0);

    run_phase(0, 0, 0, 1'b0);
    run_phase(3, 69, 0, 1'b0);
    run_phase(scwl_pkg::COUNT_MAX, 0, 69, 1'b0);
    // A limit of one walks through every slot and saturates at the last one.
    run_phase(1, 8, 8, 1'b0);
    run_phase(2, 0, 0, 1'b1);
    run_phase(scwl_pkg::COUNT_MAX, 8, 8, 1'b0);

    if (mismatch_count == 0 && awaited_responses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run of this sequence.
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
